FILE: sv/rsrp_pkg.sv
// shared types, constants and record layout tables for the robot state record parser
// no dependencies
package rsrp_pkg;

  localparam int unsigned JOINT_COUNT      = 6;
  localparam int unsigned MAX_BUFFER_BYTES = 65535;

  localparam logic [15:0] MIN_BUFFER_BYTES = 16'd5;
  localparam logic [3:0]  HEADER_BYTES     = 4'd5;
  localparam logic [2:0]  KIND_JOINTS      = 3'd1;
  localparam logic [2:0]  KIND_SKIP        = 3'd5;
  localparam logic [5:0]  JOINT_FIELDS     = 6'd8;

  // parser phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_MSG_HDR = 2'd1;
  localparam logic [1:0] PH_REC_HDR = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  // message status codes
  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_SHORT_BUF = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

  // byte width of every field, per record kind
  localparam logic [3:0] LAYOUT_WIDTH [5][16] = '{
    '{4'd8, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd8, 4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd1,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd8, 4'd8, 4'd4, 4'd1, 4'd4, 4'd4,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd2, 4'd1, 4'd1, 4'd8, 4'd8, 4'd1, 4'd1,
      4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd1, 4'd1},
    '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  localparam logic [5:0] LAYOUT_LEN [5] = '{6'd10, 6'd8, 6'd8, 6'd16, 6'd6};

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] message_bytes_left;
    logic [39:0] header_shift;
    logic [31:0] record_bytes_left;
    logic [2:0]  current_kind;
    logic [5:0]  layout_position;
    logic [2:0]  joint_counter;
    logic [3:0]  field_byte_count;
    logic [63:0] value_accumulator;
  } state_t;

  typedef struct packed {
    logic        field_valid;
    logic [2:0]  record_kind;
    logic [3:0]  field_index;
    logic [2:0]  joint_index;
    logic [63:0] field_value;
    logic [3:0]  field_bytes;
    logic [1:0]  message_status;
    logic        message_end;
  } result_t;

  function automatic logic [3:0] layout_width(input logic [2:0] kind, input logic [3:0] pos);
    logic [3:0] w;
    w = 4'd0;
    if (kind < KIND_SKIP) begin
      w = LAYOUT_WIDTH[kind][pos];
    end
    return w;
  endfunction

  function automatic logic [5:0] layout_len(input logic [2:0] kind);
    logic [5:0] n;
    n = 6'd0;
    if (kind < KIND_SKIP) begin
      n = LAYOUT_LEN[kind];
    end
    return n;
  endfunction

endpackage

FILE: sv/rsrp_step.sv
// next-state and result logic for one received byte
// depends on rsrp_pkg
module rsrp_step (
  input  rsrp_pkg::state_t  st,
  input  logic [7:0]        data_byte,
  input  logic              buffer_start,
  input  logic [15:0]       buffer_length,
  output rsrp_pkg::state_t  st_next,
  output rsrp_pkg::result_t res,
  output logic              res_valid
);

  always_comb begin
    logic [15:0] len;
    logic [31:0] size;
    logic [39:0] hs_shift;
    logic [3:0]  fbc_inc;
    logic [3:0]  w;
    logic [5:0]  lp_inc;
    logic [3:0]  jc_inc;

    st_next  = st;
    res      = '0;
    hs_shift = {st.header_shift[31:0], data_byte};
    size     = hs_shift[39:8];
    fbc_inc  = st.field_byte_count + 4'd1;
    w        = rsrp_pkg::layout_width(st.current_kind, st.layout_position[3:0]);
    lp_inc   = st.layout_position + 6'd1;
    jc_inc   = {1'b0, st.joint_counter} + 4'd1;
    len      = (32'(buffer_length) > rsrp_pkg::MAX_BUFFER_BYTES)
               ? 16'(rsrp_pkg::MAX_BUFFER_BYTES) : buffer_length;

    if (buffer_start) begin
      if (len < rsrp_pkg::MIN_BUFFER_BYTES) begin
        st_next.phase      = rsrp_pkg::PH_IDLE;
        res.message_status = rsrp_pkg::ST_SHORT_BUF;
        res.message_end    = 1'b1;
      end else begin
        st_next.phase              = rsrp_pkg::PH_MSG_HDR;
        st_next.header_shift       = {32'd0, data_byte};
        st_next.field_byte_count   = 4'd1;
        st_next.message_bytes_left = len;
      end
    end else begin
      unique case (st.phase)
        rsrp_pkg::PH_IDLE: begin
        end
        rsrp_pkg::PH_MSG_HDR: begin
          st_next.header_shift     = hs_shift;
          st_next.field_byte_count = fbc_inc;
          if (fbc_inc >= rsrp_pkg::HEADER_BYTES) begin
            st_next.field_byte_count = 4'd0;
            st_next.header_shift     = '0;
            if (size > {16'd0, st.message_bytes_left}) begin
              st_next.phase      = rsrp_pkg::PH_IDLE;
              res.message_status = rsrp_pkg::ST_SHORT_BUF;
              res.message_end    = 1'b1;
            end else if (size <= 32'd5) begin
              st_next.phase      = rsrp_pkg::PH_IDLE;
              res.message_status = rsrp_pkg::ST_DONE;
              res.message_end    = 1'b1;
            end else begin
              // size fits in 16 bits here as it is no larger than the buffer
              st_next.message_bytes_left = 16'(size - 32'd5);
              st_next.phase              = rsrp_pkg::PH_REC_HDR;
            end
          end
        end
        rsrp_pkg::PH_REC_HDR: begin
          st_next.header_shift       = hs_shift;
          st_next.field_byte_count   = fbc_inc;
          st_next.message_bytes_left = st.message_bytes_left - 16'd1;
          if (fbc_inc >= rsrp_pkg::HEADER_BYTES) begin
            st_next.field_byte_count = 4'd0;
            st_next.header_shift     = '0;
            if (size[31] || size < 32'd5) begin
              st_next.phase      = rsrp_pkg::PH_IDLE;
              res.message_status = rsrp_pkg::ST_BAD_SIZE;
              res.message_end    = 1'b1;
            end else begin
              st_next.record_bytes_left = size - 32'd5;
              st_next.current_kind      = (hs_shift[7:0] < 8'd5) ? hs_shift[2:0]
                                                                 : rsrp_pkg::KIND_SKIP;
              st_next.layout_position   = 6'd0;
              st_next.joint_counter     = 3'd0;
              st_next.value_accumulator = '0;
              st_next.phase             = (size != 32'd5) ? rsrp_pkg::PH_PAYLOAD
                                                          : rsrp_pkg::PH_REC_HDR;
            end
          end
          // bad size wins over the message running out
          if (!res.message_end && st_next.message_bytes_left == 16'd0) begin
            st_next.phase      = rsrp_pkg::PH_IDLE;
            res.message_status = rsrp_pkg::ST_DONE;
            res.message_end    = 1'b1;
          end
        end
        rsrp_pkg::PH_PAYLOAD: begin
          if (st.current_kind < rsrp_pkg::KIND_SKIP &&
              st.layout_position < rsrp_pkg::layout_len(st.current_kind)) begin
            st_next.value_accumulator = {st.value_accumulator[55:0], data_byte};
            st_next.field_byte_count  = fbc_inc;
            if (fbc_inc >= w) begin
              res.field_valid           = 1'b1;
              res.record_kind           = st.current_kind;
              res.field_index           = st.layout_position[3:0];
              res.joint_index           = (st.current_kind == rsrp_pkg::KIND_JOINTS)
                                          ? st.joint_counter : 3'd0;
              res.field_value           = {st.value_accumulator[55:0], data_byte};
              res.field_bytes           = w;
              st_next.value_accumulator = '0;
              st_next.field_byte_count  = 4'd0;
              st_next.layout_position   = lp_inc;
              if (st.current_kind == rsrp_pkg::KIND_JOINTS &&
                  lp_inc >= rsrp_pkg::JOINT_FIELDS) begin
                // wrap to the next joint until all joints are read
                if (32'(jc_inc) < rsrp_pkg::JOINT_COUNT) begin
                  st_next.joint_counter   = jc_inc[2:0];
                  st_next.layout_position = 6'd0;
                end else begin
                  st_next.layout_position = rsrp_pkg::JOINT_FIELDS;
                end
              end
            end
          end
          st_next.record_bytes_left  = st.record_bytes_left - 32'd1;
          st_next.message_bytes_left = st.message_bytes_left - 16'd1;
          if (st_next.message_bytes_left == 16'd0) begin
            st_next.phase      = rsrp_pkg::PH_IDLE;
            res.message_status = rsrp_pkg::ST_DONE;
            res.message_end    = 1'b1;
          end else if (st_next.record_bytes_left == 32'd0) begin
            st_next.phase            = rsrp_pkg::PH_REC_HDR;
            st_next.field_byte_count = 4'd0;
            st_next.header_shift     = '0;
          end
        end
        default: begin
        end
      endcase
    end

    res_valid = res.field_valid | res.message_end;
  end

endmodule

FILE: sv/robot_state_record_parser.sv
// robot status message parser: one byte in, at most one result out (a field, a message end or both)
// the result of an accepted byte is registered in the output register
// throughput one byte per cycle; input stalls only while a held result is stalled
// rst (synchronous) returns the parser to waiting for a message header
// and empties the output register
// depends on rsrp_pkg and rsrp_step
module robot_state_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_start,
  input  logic [15:0] buffer_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        field_valid,
  output logic [2:0]  record_kind,
  output logic [3:0]  field_index,
  output logic [2:0]  joint_index,
  output logic [63:0] field_value,
  output logic [3:0]  field_bytes,
  output logic [1:0]  message_status,
  output logic        message_end
);

  rsrp_pkg::state_t  st;
  rsrp_pkg::state_t  st_next;
  rsrp_pkg::result_t res_next;
  rsrp_pkg::result_t res;
  logic              res_valid;
  logic              accept;

  rsrp_step u_step (
    .st            (st),
    .data_byte     (data_byte),
    .buffer_start  (buffer_start),
    .buffer_length (buffer_length),
    .st_next       (st_next),
    .res           (res_next),
    .res_valid     (res_valid)
  );

  // a held result blocks the input only while it is itself stalled
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: rsrp_pkg::PH_IDLE, default: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (accept && res_valid) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res <= res_next;
    end
  end

  assign field_valid    = res.field_valid;
  assign record_kind    = res.record_kind;
  assign field_index    = res.field_index;
  assign joint_index    = res.joint_index;
  assign field_value    = res.field_value;
  assign field_bytes    = res.field_bytes;
  assign message_status = res.message_status;
  assign message_end    = res.message_end;

endmodule

FILE: test/rsrp_field_monitor.sv
// watches both channels of the robot state record parser, works out the field and
// message-end results each accepted byte should give and compares them in order
// depends on rsrp_pkg
module rsrp_field_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_start,
  input  logic [15:0] buffer_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        field_valid,
  input  logic [2:0]  record_kind,
  input  logic [3:0]  field_index,
  input  logic [2:0]  joint_index,
  input  logic [63:0] field_value,
  input  logic [3:0]  field_bytes,
  input  logic [1:0]  message_status,
  input  logic        message_end,
  output int          fail_count,
  output int          pending_count
);

  localparam logic [15:0] HEADER_LEN = 16'd5;

  // byte width of each field in order, per known record kind
  localparam logic [3:0] FIELD_WIDTH [5][16] = '{
    '{4'd8, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd8, 4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd1,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd8, 4'd8, 4'd4, 4'd1, 4'd4, 4'd4,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd2, 4'd1, 4'd1, 4'd8, 4'd8, 4'd1, 4'd1,
      4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd1, 4'd1},
    '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };
  localparam logic [5:0] FIELD_COUNT [5] = '{6'd10, 6'd8, 6'd8, 6'd16, 6'd6};

  logic [1:0]  parse_phase;
  logic [15:0] msg_left;
  logic [39:0] hdr_shift;
  logic [31:0] rec_left;
  logic [2:0]  cur_kind;
  logic [5:0]  lay_pos;
  logic [2:0]  joint_no;
  logic [3:0]  byte_cnt;
  logic [63:0] accum;

  rsrp_pkg::result_t expected_fields [$];

  task automatic report(input string what);
    $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic end_message(inout rsrp_pkg::result_t r, input logic [1:0] status);
    parse_phase = rsrp_pkg::PH_IDLE;
    r.message_status = status;
    r.message_end = 1'b1;
  endtask

  // advance the parser model by one byte
  task automatic parse_byte(input logic [7:0] b, input logic st, input logic [15:0] blen,
                            output bit made, output rsrp_pkg::result_t r);
    logic [31:0] size;
    logic [7:0]  rtype;
    logic [3:0]  w;
    r = '0;
    if (st) begin
      if (blen < HEADER_LEN) begin
        end_message(r, rsrp_pkg::ST_SHORT_BUF);
      end else begin
        parse_phase = rsrp_pkg::PH_MSG_HDR;
        hdr_shift = {32'd0, b};
        byte_cnt = 4'd1;
        msg_left = blen;
      end
    end else begin
      case (parse_phase)
        rsrp_pkg::PH_MSG_HDR: begin
          hdr_shift = {hdr_shift[31:0], b};
          byte_cnt++;
          if (byte_cnt >= HEADER_LEN[3:0]) begin
            size = hdr_shift[39:8];
            byte_cnt = 4'd0;
            hdr_shift = '0;
            if (size > {16'd0, msg_left}) begin
              end_message(r, rsrp_pkg::ST_SHORT_BUF);
            end else if (size <= {16'd0, HEADER_LEN}) begin
              end_message(r, rsrp_pkg::ST_DONE);
            end else begin
              msg_left = size[15:0] - HEADER_LEN;
              parse_phase = rsrp_pkg::PH_REC_HDR;
            end
          end
        end
        rsrp_pkg::PH_REC_HDR: begin
          hdr_shift = {hdr_shift[31:0], b};
          byte_cnt++;
          msg_left--;
          if (byte_cnt >= HEADER_LEN[3:0]) begin
            size = hdr_shift[39:8];
            rtype = hdr_shift[7:0];
            byte_cnt = 4'd0;
            hdr_shift = '0;
            if (size[31] || size < {16'd0, HEADER_LEN}) begin
              end_message(r, rsrp_pkg::ST_BAD_SIZE);
            end else begin
              rec_left = size - {16'd0, HEADER_LEN};
              cur_kind = (rtype < {5'd0, rsrp_pkg::KIND_SKIP}) ? rtype[2:0]
                                                               : rsrp_pkg::KIND_SKIP;
              lay_pos = '0;
              joint_no = '0;
              accum = '0;
              parse_phase = (rec_left != 0) ? rsrp_pkg::PH_PAYLOAD : rsrp_pkg::PH_REC_HDR;
            end
          end
          // bad size wins over the message running out on the same byte
          if (parse_phase != rsrp_pkg::PH_IDLE && msg_left == 0) begin
            end_message(r, rsrp_pkg::ST_DONE);
          end
        end
        rsrp_pkg::PH_PAYLOAD: begin
          if (cur_kind < rsrp_pkg::KIND_SKIP && lay_pos < FIELD_COUNT[cur_kind]) begin
            w = FIELD_WIDTH[cur_kind][lay_pos[3:0]];
            accum = {accum[55:0], b};
            byte_cnt++;
            if (byte_cnt >= w) begin
              r.field_valid = 1'b1;
              r.record_kind = cur_kind;
              r.field_index = lay_pos[3:0];
              r.joint_index = (cur_kind == rsrp_pkg::KIND_JOINTS) ? joint_no : 3'd0;
              r.field_value = accum;
              r.field_bytes = w;
              accum = '0;
              byte_cnt = 4'd0;
              lay_pos++;
              if (cur_kind == rsrp_pkg::KIND_JOINTS && lay_pos >= rsrp_pkg::JOINT_FIELDS) begin
                if (int'(joint_no) + 1 < rsrp_pkg::JOINT_COUNT) begin
                  joint_no++;
                  lay_pos = '0;
                end else begin
                  lay_pos = rsrp_pkg::JOINT_FIELDS;
                end
              end
            end
          end
          rec_left--;
          msg_left--;
          if (msg_left == 0) begin
            end_message(r, rsrp_pkg::ST_DONE);
          end else if (rec_left == 0) begin
            parse_phase = rsrp_pkg::PH_REC_HDR;
            byte_cnt = 4'd0;
            hdr_shift = '0;
          end
        end
        default: ;
      endcase
    end
    made = r.field_valid || r.message_end;
  endtask

  always @(posedge clk) begin
    rsrp_pkg::result_t want;
    bit made;
    if (rst) begin
      parse_phase = rsrp_pkg::PH_IDLE;
      msg_left = '0;
      hdr_shift = '0;
      rec_left = '0;
      cur_kind = '0;
      lay_pos = '0;
      joint_no = '0;
      byte_cnt = '0;
      accum = '0;
      expected_fields.delete();
    end else begin
      // results first: a byte accepted now cannot show before the next edge
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report("result with nothing pending");
        end else begin
          want = expected_fields.pop_front();
          check_field("field_valid", field_valid, want.field_valid);
          check_field("record_kind", record_kind, want.record_kind);
          check_field("field_index", field_index, want.field_index);
          check_field("joint_index", joint_index, want.joint_index);
          check_field("field_value", field_value, want.field_value);
          check_field("field_bytes", field_bytes, want.field_bytes);
          check_field("message_status", message_status, want.message_status);
          check_field("message_end", message_end, want.message_end);
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, buffer_start, buffer_length, made, want);
        if (made) begin
          expected_fields.insert(expected_fields.size(), want);
        end
      end
    end
    pending_count = expected_fields.size();
  end

endmodule

FILE: test/testbench.sv
// top of the robot state record parser bench: drives byte requests and output stalls,
// builds whole and broken status messages, and gives the verdict
// depends on rsrp_pkg, robot_state_record_parser and rsrp_field_monitor
module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 390;
  // payload bytes that fill each known record layout
  localparam int FULL_BYTES [5] = '{24, 246, 31, 58, 48};
  localparam int IDLE_PCT [4] = '{0, 55, 0, 35};
  localparam int STALL_PCT [4] = '{0, 0, 55, 35};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        buffer_start = 1'b0;
  logic [15:0] buffer_length = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        field_valid;
  logic [2:0]  record_kind;
  logic [3:0]  field_index;
  logic [2:0]  joint_index;
  logic [63:0] field_value;
  logic [3:0]  field_bytes;
  logic [1:0]  message_status;
  logic        message_end;
  int          fail_count;
  int          pending_count;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [7:0]  msg_q [$];
  logic [15:0] msg_len;
  int          live_bytes;
  int          stray_bytes;

  robot_state_record_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .buffer_start(buffer_start), .buffer_length(buffer_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .field_valid(field_valid), .record_kind(record_kind), .field_index(field_index),
    .joint_index(joint_index), .field_value(field_value), .field_bytes(field_bytes),
    .message_status(message_status), .message_end(message_end)
  );

  rsrp_field_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .buffer_start(buffer_start), .buffer_length(buffer_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .field_valid(field_valid), .record_kind(record_kind), .field_index(field_index),
    .joint_index(joint_index), .field_value(field_value), .field_bytes(field_bytes),
    .message_status(message_status), .message_end(message_end),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** robot_state_record_parser: FAILED **");
        $finish;
      end
    end
  end

  // one byte request, held until taken; returns on a falling edge
  task automatic send_byte(input logic [7:0] d, input logic st, input logic [15:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    buffer_start <= st;
    buffer_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_msg(input logic [15:0] len);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == 0, (i == 0) ? len : 16'($urandom_range(65535)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  function automatic void add_record();
    int sel;
    int plen;
    logic [7:0] rtype;
    sel = $urandom_range(99);
    if (sel < 78) begin
      rtype = 8'($urandom_range(4));
    end else if (sel < 86) begin
      rtype = 8'd20;
    end else begin
      rtype = 8'($urandom_range(5, 255));
    end
    if (rtype < 8'd5) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        plen = FULL_BYTES[rtype];
      end else if (sel < 65) begin
        plen = FULL_BYTES[rtype] + $urandom_range(1, 6);
      end else if (sel < 90) begin
        plen = $urandom_range(0, FULL_BYTES[rtype] - 1);
      end else begin
        plen = 0;
      end
      // keep most joint records short so the run sees many messages
      if (rtype == 8'd1 && plen > 60 && $urandom_range(1) == 0) begin
        plen = $urandom_range(1, 60);
      end
    end else begin
      plen = $urandom_range(12);
    end
    push_word(32'(plen + 5));
    add_byte(rtype);
    repeat (plen) add_byte(8'($urandom_range(255)));
  endfunction

  // one buffer, whole or broken in one of several ways
  task automatic make_message();
    int sel;
    int total;
    int cut;
    logic [31:0] decl;
    logic [31:0] base;
    msg_q.delete();
    stray_bytes = 0;
    sel = $urandom_range(99);
    if (sel >= 88 && sel < 92) begin
      // too short for a message header
      add_byte(8'($urandom_range(255)));
      msg_len = 16'($urandom_range(4));
      live_bytes = 1;
      stray_bytes = $urandom_range(2);
    end else begin
      push_word(32'd0);
      add_byte(8'($urandom_range(255)));
      repeat ((sel >= 70 && sel < 78) ? $urandom_range(2) : $urandom_range(1, 4)) add_record();
      if (sel >= 70 && sel < 78) begin
        // sub-record with a size below its own header, or negative
        push_word($urandom_range(1) ? 32'($urandom_range(4)) : (32'h8000_0000 | $urandom()));
        add_byte(8'($urandom_range(255)));
        repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
      end
      total = msg_q.size();
      decl = 32'(total);
      live_bytes = total;
      if (sel >= 60 && sel < 70) begin
        decl = $urandom_range(6, total);
        live_bytes = decl;
      end else if (sel >= 84 && sel < 88) begin
        decl = $urandom_range(5);
        live_bytes = 5;
      end
      if (sel >= 78 && sel < 84) begin
        if ($urandom_range(1)) decl = $urandom() | 32'h0001_0000;
        msg_len = (decl > 32'd65535) ? 16'($urandom_range(5, 65535))
                                     : 16'($urandom_range(5, decl - 1));
        live_bytes = 5;
        stray_bytes = $urandom_range(2);
      end else begin
        base = (decl < 32'd5) ? 32'd5 : decl;
        msg_len = $urandom_range(1) ? base[15:0] : 16'($urandom_range(base, 65535));
      end
      msg_q[0] = decl[31:24];
      msg_q[1] = decl[23:16];
      msg_q[2] = decl[15:8];
      msg_q[3] = decl[7:0];
      if (sel >= 92) begin
        // cut off by the next buffer
        cut = $urandom_range(1, total - 1);
        live_bytes = cut;
      end else begin
        cut = live_bytes;
        if (sel < 60 && $urandom_range(1)) stray_bytes = $urandom_range(1, 2);
      end
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endtask

  initial begin
    int items;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short buffer with empty length, then a byte outside any buffer
    msg_q = '{8'hFF};
    send_msg(16'd0);
    send_byte(8'h00, 1'b0, 16'hFFFF);
    // empty message in the largest buffer
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h10};
    send_msg(16'hFFFF);
    // abandoned by the next buffer
    msg_q = '{8'h00, 8'h00};
    send_msg(16'd9);
    // message size above the buffer length
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h06, 8'h10};
    send_msg(16'd5);
    // bad record size on the very byte the message runs out
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h0A, 8'h10, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01};
    send_msg(16'd10);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      items = 0;
      while (items < PHASE_BYTES) begin
        make_message();
        send_msg(msg_len);
        repeat (stray_bytes) send_byte(8'($urandom_range(255)), 1'b0,
                                       16'($urandom_range(65535)));
        items += live_bytes;
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("** robot_state_record_parser: PASSED **");
    end else begin
      $display("** robot_state_record_parser: FAILED **");
    end
    $finish;
  end

endmodule
